### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker module of the EP0 responder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on i_clk, off while i_rst_n is low
`define ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ep0r check failed");

// next-cycle implication, clocked on i_clk, off while i_rst_n is low
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ep0r check failed");

`endif

### sv/ep0r_pkg.sv
// ----------------------------------------------------------------------------
// ep0r_pkg
// Constants, types and descriptor tables of the EP0 request responder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ep0r_pkg;

    // build-time configuration
    localparam int EP0_PACKET_SIZE  = 64;
    localparam int STRING_COUNT     = 3;
    localparam int MAX_STRING_CHARS = 32;

    // text ROM geometry
    localparam int ROM_WIDTH  = 23;
    localparam int TEXT_COLS  = ROM_WIDTH - 1;
    localparam int TEXT_SLOTS = 3;

    // state memory
    localparam int STATE_DEPTH = 2;
    localparam logic STATE_ADDR = 1'b0;

    // configuration register indexes
    localparam logic [2:0] CFG_VENDOR_ID      = 3'd0;
    localparam logic [2:0] CFG_PRODUCT_ID     = 3'd1;
    localparam logic [2:0] CFG_DEVICE_RELEASE = 3'd2;
    localparam logic [2:0] CFG_MAX_POWER      = 3'd3;
    localparam logic [2:0] CFG_VENDOR_CODE    = 3'd4;

    // standard request codes
    localparam logic [7:0] REQ_GET_STATUS        = 8'd0;
    localparam logic [7:0] REQ_SET_ADDRESS       = 8'd5;
    localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'd6;
    localparam logic [7:0] REQ_GET_CONFIGURATION = 8'd8;
    localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;
    localparam logic [7:0] REQ_GET_INTERFACE     = 8'd10;
    localparam logic [7:0] REQ_SET_INTERFACE     = 8'd11;

    // descriptor types
    localparam logic [7:0] DT_DEVICE     = 8'd1;
    localparam logic [7:0] DT_CONFIG     = 8'd2;
    localparam logic [7:0] DT_STRING     = 8'd3;
    localparam logic [7:0] DT_QUALIFIER  = 8'd6;
    localparam logic [7:0] DT_OTHER_SPD  = 8'd7;

    // vendor request matching
    localparam logic [7:0]  STR_IDX_OS     = 8'hEE;
    localparam logic [7:0]  VENDOR_IN_TYPE = 8'hC0;
    localparam logic [15:0] COMPAT_INDEX   = 16'h0004;

    // reply lengths
    localparam logic [5:0] LEN_ONE    = 6'd1;
    localparam logic [5:0] LEN_STATUS = 6'd2;
    localparam logic [5:0] LEN_LANG   = 6'd4;
    localparam logic [5:0] LEN_QUAL   = 6'd10;
    localparam logic [5:0] LEN_DEVICE = 6'd18;
    localparam logic [5:0] LEN_CONFIG = 6'd18;
    localparam logic [5:0] LEN_OS     = 6'd18;
    localparam logic [5:0] LEN_COMPAT = 6'd40;

    // reply byte sources
    typedef logic [3:0] t_src;
    localparam t_src SRC_ZERO   = 4'd0;
    localparam t_src SRC_ACTCFG = 4'd1;
    localparam t_src SRC_DEV    = 4'd2;
    localparam t_src SRC_CFG    = 4'd3;
    localparam t_src SRC_QUAL   = 4'd4;
    localparam t_src SRC_LANG   = 4'd5;
    localparam t_src SRC_OS     = 4'd6;
    localparam t_src SRC_STR    = 4'd7;
    localparam t_src SRC_COMPAT = 4'd8;

    // decode outcome
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_STALL = 2'd0;
    localparam t_kind KIND_EMPTY = 2'd1;
    localparam t_kind KIND_ADDR  = 2'd2;
    localparam t_kind KIND_RUN   = 2'd3;

    typedef struct packed {
        logic [15:0] vendor_id;
        logic [15:0] product_id;
        logic [15:0] device_release;
        logic [7:0]  max_power;
        logic [7:0]  vendor_code;
    } t_cfg_regs;

    typedef struct packed {
        t_kind       kind;
        t_src        src;
        logic [5:0]  full_len;
        logic        set_cfg;
        logic        cfg_val;
        logic        other_speed;
        logic [3:0]  slot;
    } t_decision;

    typedef struct packed {
        t_src        src;
        logic        other_speed;
        logic [3:0]  slot;
        logic        act_cfg;
    } t_reply_ctx;

    typedef struct packed {
        logic        act_cfg;
        logic [5:0]  reply_cnt;
    } t_state_word;

    localparam int STATE_W = $bits(t_state_word);

    // string text, one row per slot, zero padded
    localparam logic [7:0] TEXT_ROM [TEXT_SLOTS][TEXT_COLS] = '{
        '{"A", "c", "m", "e", "C", "h", "i", "p", "s", 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"G", "e", "n", "e", "r", "i", "c", " ", "E", "P", "0",
          " ", "U", "S", "B", " ", "D", "e", "v", "i", "c", "e"},
        '{"0", "0", "0", "1", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam int TEXT_LEN [TEXT_SLOTS] = '{9, 22, 4};

    // OS string signature characters
    localparam logic [7:0] OS_SIG [7] = '{
        8'h4d, 8'h53, 8'h46, 8'h54, 8'h31, 8'h30, 8'h30
    };

    // extended compatible-ID descriptor
    localparam logic [7:0] COMPAT_ROM [40] = '{
        8'h28, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h04, 8'h00, 8'h01, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h57, 8'h49,
        8'h4e, 8'h55, 8'h53, 8'h42, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // characters sent for a string slot, after both cuts
    function automatic logic [4:0] str_chars(input logic [3:0] slot);
        int c;
        c = 0;
        if (slot < 4'(TEXT_SLOTS)) begin
            c = TEXT_LEN[slot[1:0]];
        end
        if (c > TEXT_COLS) begin
            c = TEXT_COLS;
        end
        if (c > MAX_STRING_CHARS) begin
            c = MAX_STRING_CHARS;
        end
        return 5'(c);
    endfunction

    // one text character, zero outside the table
    function automatic logic [7:0] text_char(input logic [3:0] slot, input logic [4:0] pos);
        if (slot < 4'(TEXT_SLOTS) && pos < 5'(TEXT_COLS)) begin
            return TEXT_ROM[slot[1:0]][pos];
        end
        return 8'h00;
    endfunction

    // string index placed in the device descriptor
    function automatic logic [7:0] str_index(input int i);
        return (i <= STRING_COUNT) ? 8'(i) : 8'h00;
    endfunction

endpackage

### sv/usb_ep0_request_responder_unit.sv
// ----------------------------------------------------------------------------
// usb_ep0_request_responder_unit
// USB control endpoint request responder: decodes one setup packet or bus
// reset per command and streams the reply as single-cycle result strobes.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. A bus reset gives
// no result. A setup packet that answers with a single result (stall,
// zero-length or SET_ADDRESS) first reads the state memory, then decodes and
// writes it back. A data reply of n bytes (n = min(wLength, descriptor
// length), at most 46) follows the same read and decode and is then streamed
// one byte per cycle from the reply byte generator. Results cannot be held
// off: each one is on the o_ ports for exactly the cycle that o_strobe is
// high, and the bytes of one reply come on consecutive cycles, o_last on
// the final one. After reset the block clears the state memory with busy
// high; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module usb_ep0_request_responder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        start,
    output logic        busy,
    input  logic        i_req_type,
    input  logic [7:0]  i_request_type,
    input  logic [7:0]  i_request_code,
    input  logic [15:0] i_setup_value,
    input  logic [15:0] i_setup_index,
    input  logic [15:0] i_setup_length,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // result channel
    output logic        o_strobe,
    output logic        o_status,
    output logic        o_has_data,
    output logic [7:0]  o_data_byte,
    output logic        o_last,
    output logic        o_address_valid,
    output logic [6:0]  o_new_address
);
    import ep0r_pkg::*;

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_DECODE = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    logic [1:0]   r_state, n_state;
    t_cfg_regs    r_cfg;

    logic [7:0]   r_request_type;
    logic [7:0]   r_request_code;
    logic [15:0]  r_setup_value;
    logic [15:0]  r_setup_index;
    logic [15:0]  r_setup_length;

    t_reply_ctx   r_ctx, n_ctx;
    logic [5:0]   r_len, n_len;
    logic [5:0]   r_pos, n_pos;

    logic         r_strobe, n_strobe;
    logic         r_status, n_status;
    logic         r_has_data, n_has_data;
    logic [7:0]   r_data_byte, n_data_byte;
    logic         r_last, n_last;
    logic         r_address_valid, n_address_valid;
    logic [6:0]   r_new_address, n_new_address;

    logic         accept;
    logic         ram_we;
    logic         ram_re;
    t_state_word  ram_wdata;
    logic [STATE_W-1:0] ram_rdata;
    t_state_word  cur_word;

    t_decision    dec;
    logic [7:0]   rom_byte;
    logic [5:0]   run_len;
    logic         is_run;
    logic         emit_last;

    assign busy     = (r_state != ST_IDLE);
    assign accept   = start && !busy;
    assign cur_word = t_state_word'(ram_rdata);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.vendor_id      <= 16'h7D4A;
            r_cfg.product_id     <= 16'h2B82;
            r_cfg.device_release <= 16'h0002;
            r_cfg.max_power      <= 8'd50;
            r_cfg.vendor_code    <= 8'h20;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_VENDOR_ID:      r_cfg.vendor_id      <= i_cfg_data;
                CFG_PRODUCT_ID:     r_cfg.product_id     <= i_cfg_data;
                CFG_DEVICE_RELEASE: r_cfg.device_release <= i_cfg_data;
                CFG_MAX_POWER:      r_cfg.max_power      <= i_cfg_data[7:0];
                CFG_VENDOR_CODE:    r_cfg.vendor_code    <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // setup packet capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_request_type <= i_request_type;
            r_request_code <= i_request_code;
            r_setup_value  <= i_setup_value;
            r_setup_index  <= i_setup_index;
            r_setup_length <= i_setup_length;
        end
    end

    // state memory: configuration value and reply counter
    ep0r_ram #(
        .WIDTH (STATE_W),
        .DEPTH (STATE_DEPTH)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (STATE_ADDR),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (STATE_ADDR),
        .o_rdata (ram_rdata)
    );

    ep0r_decode u_decode (
        .i_request_type (r_request_type),
        .i_request_code (r_request_code),
        .i_setup_value  (r_setup_value),
        .i_setup_index  (r_setup_index),
        .i_cfg          (r_cfg),
        .o_dec          (dec)
    );

    ep0r_reply_rom u_reply_rom (
        .i_ctx  (r_ctx),
        .i_cfg  (r_cfg),
        .i_pos  (r_pos),
        .o_byte (rom_byte)
    );

    // reply length cut to wLength
    assign run_len   = (r_setup_length < 16'(dec.full_len)) ? r_setup_length[5:0]
                                                             : dec.full_len;
    assign is_run    = (dec.kind == KIND_RUN) && (run_len != 6'd0);
    assign emit_last = (r_pos == r_len - 6'd1);

    // sequencer: read, decode and write back, then stream
    always_comb begin
        n_state         = r_state;
        n_ctx           = r_ctx;
        n_len           = r_len;
        n_pos           = r_pos;
        n_strobe        = 1'b0;
        n_status        = 1'b0;
        n_has_data      = 1'b0;
        n_data_byte     = 8'h00;
        n_last          = 1'b0;
        n_address_valid = 1'b0;
        n_new_address   = 7'h00;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_wdata       = '0;
        case (r_state)
            ST_CLEAR: begin
                ram_we  = 1'b1;
                n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    if (i_req_type) begin
                        // bus reset: unconfigured, no result
                        ram_we = 1'b1;
                    end else begin
                        ram_re  = 1'b1;
                        n_state = ST_DECODE;
                    end
                end
            end
            ST_DECODE: begin
                ram_we              = 1'b1;
                ram_wdata.act_cfg   = dec.set_cfg ? dec.cfg_val : cur_word.act_cfg;
                ram_wdata.reply_cnt = is_run ? run_len : 6'd0;
                n_ctx.src           = dec.src;
                n_ctx.other_speed   = dec.other_speed;
                n_ctx.slot          = dec.slot;
                n_ctx.act_cfg       = cur_word.act_cfg;
                n_len               = run_len;
                n_pos               = 6'd0;
                if (is_run) begin
                    n_state = ST_EMIT;
                end else begin
                    // single result: stall, zero-length or new address
                    n_strobe        = 1'b1;
                    n_last          = 1'b1;
                    n_status        = (dec.kind == KIND_STALL);
                    n_address_valid = (dec.kind == KIND_ADDR);
                    n_new_address   = (dec.kind == KIND_ADDR) ? r_setup_value[6:0] : 7'h00;
                    n_state         = ST_IDLE;
                end
            end
            ST_EMIT: begin
                n_strobe    = 1'b1;
                n_has_data  = 1'b1;
                n_data_byte = rom_byte;
                n_last      = emit_last;
                n_pos       = r_pos + 6'd1;
                if (emit_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    // reply context and result payload
    always_ff @(posedge i_clk) begin
        r_ctx           <= n_ctx;
        r_len           <= n_len;
        r_pos           <= n_pos;
        r_status        <= n_status;
        r_has_data      <= n_has_data;
        r_data_byte     <= n_data_byte;
        r_last          <= n_last;
        r_address_valid <= n_address_valid;
        r_new_address   <= n_new_address;
    end

    assign o_strobe        = r_strobe;
    assign o_status        = r_status;
    assign o_has_data      = r_has_data;
    assign o_data_byte     = r_data_byte;
    assign o_last          = r_last;
    assign o_address_valid = r_address_valid;
    assign o_new_address   = r_new_address;

endmodule

### sv/ep0r_ram.sv
// ----------------------------------------------------------------------------
// ep0r_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ep0r_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/ep0r_decode.sv
// ----------------------------------------------------------------------------
// ep0r_decode
// Setup packet decoder: picks the reply source, its full length and the
// kind of result (stall, empty, address or byte run).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ep0r_decode (
    input  logic [7:0]            i_request_type,
    input  logic [7:0]            i_request_code,
    input  logic [15:0]           i_setup_value,
    input  logic [15:0]           i_setup_index,
    input  ep0r_pkg::t_cfg_regs   i_cfg,
    output ep0r_pkg::t_decision   o_dec
);
    import ep0r_pkg::*;

    logic [7:0] dtype;
    logic [7:0] didx;
    logic [3:0] slot;

    assign dtype = i_setup_value[15:8];
    assign didx  = i_setup_value[7:0];
    assign slot  = 4'(didx - 8'd1);

    always_comb begin
        o_dec      = '0;
        o_dec.kind = KIND_STALL;
        if (i_request_type[6:5] != 2'b00) begin
            // vendor/class: only the compatible-ID read is served
            if (i_request_type == VENDOR_IN_TYPE && i_request_code == i_cfg.vendor_code &&
                i_setup_value == 16'h0000 && i_setup_index == COMPAT_INDEX) begin
                o_dec.kind     = KIND_RUN;
                o_dec.src      = SRC_COMPAT;
                o_dec.full_len = LEN_COMPAT;
            end
        end else begin
            case (i_request_code)
                REQ_GET_STATUS: begin
                    o_dec.kind     = KIND_RUN;
                    o_dec.src      = SRC_ZERO;
                    o_dec.full_len = LEN_STATUS;
                end
                REQ_SET_ADDRESS: begin
                    o_dec.kind = KIND_ADDR;
                end
                REQ_GET_DESCRIPTOR: begin
                    case (dtype)
                        DT_DEVICE: begin
                            o_dec.kind     = KIND_RUN;
                            o_dec.src      = SRC_DEV;
                            o_dec.full_len = LEN_DEVICE;
                        end
                        DT_CONFIG, DT_OTHER_SPD: begin
                            if (didx == 8'h00) begin
                                o_dec.kind        = KIND_RUN;
                                o_dec.src         = SRC_CFG;
                                o_dec.full_len    = LEN_CONFIG;
                                o_dec.other_speed = (dtype == DT_OTHER_SPD);
                            end
                        end
                        DT_QUALIFIER: begin
                            o_dec.kind     = KIND_RUN;
                            o_dec.src      = SRC_QUAL;
                            o_dec.full_len = LEN_QUAL;
                        end
                        DT_STRING: begin
                            if (didx == 8'h00) begin
                                o_dec.kind     = KIND_RUN;
                                o_dec.src      = SRC_LANG;
                                o_dec.full_len = LEN_LANG;
                            end else if (didx == STR_IDX_OS) begin
                                o_dec.kind     = KIND_RUN;
                                o_dec.src      = SRC_OS;
                                o_dec.full_len = LEN_OS;
                            end else if (didx <= 8'(STRING_COUNT)) begin
                                o_dec.kind     = KIND_RUN;
                                o_dec.src      = SRC_STR;
                                o_dec.slot     = slot;
                                o_dec.full_len = 6'd2 + {str_chars(slot), 1'b0};
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                REQ_GET_CONFIGURATION: begin
                    o_dec.kind     = KIND_RUN;
                    o_dec.src      = SRC_ACTCFG;
                    o_dec.full_len = LEN_ONE;
                end
                REQ_SET_CONFIGURATION: begin
                    if (i_setup_value <= 16'd1) begin
                        o_dec.kind    = KIND_EMPTY;
                        o_dec.set_cfg = 1'b1;
                        o_dec.cfg_val = i_setup_value[0];
                    end
                end
                REQ_GET_INTERFACE: begin
                    o_dec.kind     = KIND_RUN;
                    o_dec.src      = SRC_ZERO;
                    o_dec.full_len = LEN_ONE;
                end
                REQ_SET_INTERFACE: begin
                    if (i_setup_value == 16'h0000 && i_setup_index == 16'h0000) begin
                        o_dec.kind = KIND_EMPTY;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

### sv/ep0r_reply_rom.sv
// ----------------------------------------------------------------------------
// ep0r_reply_rom
// Reply byte generator: gives the byte at one position of the selected
// descriptor or status reply, built from tables and configuration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ep0r_reply_rom (
    input  ep0r_pkg::t_reply_ctx  i_ctx,
    input  ep0r_pkg::t_cfg_regs   i_cfg,
    input  logic [5:0]            i_pos,
    output logic [7:0]            o_byte
);
    import ep0r_pkg::*;

    logic [5:0] str_len;
    logic [4:0] char_pos;

    assign str_len  = 6'd2 + {str_chars(i_ctx.slot), 1'b0};
    // even positions from 2 on carry characters
    assign char_pos = 5'(i_pos[5:1] - 5'd1);

    always_comb begin
        o_byte = 8'h00;
        case (i_ctx.src)
            SRC_ZERO: begin
                o_byte = 8'h00;
            end
            SRC_ACTCFG: begin
                o_byte = {7'b0, i_ctx.act_cfg};
            end
            SRC_DEV: begin
                case (i_pos)
                    6'd0:    o_byte = 8'(LEN_DEVICE);
                    6'd1:    o_byte = DT_DEVICE;
                    6'd3:    o_byte = 8'h02;
                    6'd7:    o_byte = 8'(EP0_PACKET_SIZE);
                    6'd8:    o_byte = i_cfg.vendor_id[7:0];
                    6'd9:    o_byte = i_cfg.vendor_id[15:8];
                    6'd10:   o_byte = i_cfg.product_id[7:0];
                    6'd11:   o_byte = i_cfg.product_id[15:8];
                    6'd12:   o_byte = i_cfg.device_release[7:0];
                    6'd13:   o_byte = i_cfg.device_release[15:8];
                    6'd14:   o_byte = str_index(1);
                    6'd15:   o_byte = str_index(2);
                    6'd16:   o_byte = str_index(3);
                    6'd17:   o_byte = 8'h01;
                    default: o_byte = 8'h00;
                endcase
            end
            SRC_CFG: begin
                case (i_pos)
                    6'd0:    o_byte = 8'h09;
                    6'd1:    o_byte = i_ctx.other_speed ? DT_OTHER_SPD : DT_CONFIG;
                    6'd2:    o_byte = 8'(LEN_CONFIG);
                    6'd4:    o_byte = 8'h01;
                    6'd5:    o_byte = 8'h01;
                    6'd7:    o_byte = 8'h80;
                    6'd8:    o_byte = i_cfg.max_power;
                    6'd9:    o_byte = 8'h09;
                    6'd10:   o_byte = 8'h04;
                    6'd14:   o_byte = 8'hFF;
                    default: o_byte = 8'h00;
                endcase
            end
            SRC_QUAL: begin
                case (i_pos)
                    6'd0:    o_byte = 8'(LEN_QUAL);
                    6'd1:    o_byte = DT_QUALIFIER;
                    6'd3:    o_byte = 8'h02;
                    6'd7:    o_byte = 8'(EP0_PACKET_SIZE);
                    6'd8:    o_byte = 8'h01;
                    default: o_byte = 8'h00;
                endcase
            end
            SRC_LANG: begin
                case (i_pos)
                    6'd0:    o_byte = 8'(LEN_LANG);
                    6'd1:    o_byte = DT_STRING;
                    6'd2:    o_byte = 8'h09;
                    6'd3:    o_byte = 8'h04;
                    default: o_byte = 8'h00;
                endcase
            end
            SRC_OS: begin
                if (i_pos == 6'd0) begin
                    o_byte = 8'(LEN_OS);
                end else if (i_pos == 6'd1) begin
                    o_byte = DT_STRING;
                end else if (i_pos <= 6'd14 && !i_pos[0]) begin
                    o_byte = OS_SIG[3'(char_pos)];
                end else if (i_pos == 6'd16) begin
                    o_byte = i_cfg.vendor_code;
                end
            end
            SRC_STR: begin
                // UTF-16LE: character in the low byte, zero high byte
                if (i_pos == 6'd0) begin
                    o_byte = {2'b00, str_len};
                end else if (i_pos == 6'd1) begin
                    o_byte = DT_STRING;
                end else if (!i_pos[0]) begin
                    o_byte = text_char(i_ctx.slot, char_pos);
                end
            end
            SRC_COMPAT: begin
                if (i_pos < LEN_COMPAT) begin
                    o_byte = COMPAT_ROM[i_pos];
                end
            end
            default: begin
                o_byte = 8'h00;
            end
        endcase
    end

endmodule

### sv/ep0r_chk.sv
// ----------------------------------------------------------------------------
// ep0r_chk
// Port-level checker of the EP0 request responder, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ep0r_chk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        i_req_type,
    input  logic        o_strobe,
    input  logic        o_status,
    input  logic        o_has_data,
    input  logic [7:0]  o_data_byte,
    input  logic        o_last,
    input  logic        o_address_valid
);

    // a stall never carries a data byte
    `ASSERT_IMPLY(a_stall_no_data, o_strobe && o_status, !o_has_data && o_data_byte == 8'h00)

    // a result without data is the only result of its transaction
    `ASSERT_IMPLY(a_single_last, o_strobe && !o_has_data, o_last)

    // new address only on a single, successful, dataless result
    `ASSERT_IMPLY(a_addr_single, o_strobe && o_address_valid, o_last && !o_status && !o_has_data)

    // a setup packet keeps the block busy while it is decoded
    `ASSERT_NEXT(a_setup_busy, start && !busy && !i_req_type, busy)

    // a data run comes without gaps up to its last byte
    `ASSERT_NEXT(a_run_contig, o_strobe && !o_last, o_strobe && o_has_data)

endmodule

bind usb_ep0_request_responder_unit ep0r_chk u_ep0r_chk (.*);

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the EP0 request responder. Setup packets and
// bus resets are sent as command transactions in random bursts. A scoreboard
// class predicts every reply byte, stall and address result, and checks each
// result strobe in order. Several register settings are covered, the
// extremes among them.
// ----------------------------------------------------------------------------

import ep0r_pkg::*;

// one command transaction: a setup packet or a bus reset
typedef struct packed {
    logic        bus_reset;
    logic [7:0]  rtype;
    logic [7:0]  code;
    logic [15:0] value;
    logic [15:0] index;
    logic [15:0] length;
} t_ep0_cmd;

// one result strobe
typedef struct packed {
    logic        status;
    logic        has_data;
    logic [7:0]  data;
    logic        last;
    logic        addr_valid;
    logic [6:0]  addr;
} t_ep0_reply;

class ep0_reply_scoreboard;
    // mirror of the register port
    logic [15:0] vendor_id;
    logic [15:0] product_id;
    logic [15:0] release_bcd;
    logic [7:0]  power_2ma;
    logic [7:0]  vendor_code;
    // device state
    logic        configured;
    logic [5:0]  bytes_sent;
    // expected results, oldest first
    t_ep0_reply  pending_replies[$];
    logic [7:0]  desc[64];
    string       str_text[3];
    int          err_count;
    int          cmd_count;
    int          reply_count;
    int          stall_count;
    int          byte_count;

    function new();
        vendor_id   = 16'h7d4a;
        product_id  = 16'h2b82;
        release_bcd = 16'h0002;
        power_2ma   = 8'd50;
        vendor_code = 8'h20;
        configured  = 1'b0;
        bytes_sent  = 6'd0;
        str_text    = '{"AcmeChips", "Generic EP0 USB Device", "0001"};
        err_count   = 0;
        cmd_count   = 0;
        reply_count = 0;
        stall_count = 0;
        byte_count  = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] data);
        case (idx)
            CFG_VENDOR_ID:      vendor_id = data;
            CFG_PRODUCT_ID:     product_id = data;
            CFG_DEVICE_RELEASE: release_bcd = data;
            CFG_MAX_POWER:      power_2ma = data[7:0];
            CFG_VENDOR_CODE:    vendor_code = data[7:0];
            default: ;
        endcase
    endfunction

    // single result: stall, zero-length success or new address
    function void push_single(logic stall, logic addr_ok, logic [6:0] addr);
        t_ep0_reply r;
        r = '0;
        r.status     = stall;
        r.last       = 1'b1;
        r.addr_valid = addr_ok;
        r.addr       = addr;
        pending_replies.push_back(r);
        bytes_sent = 6'd0;
        if (stall) begin
            stall_count++;
        end
    endfunction

    // byte run from desc, cut to the host's length
    function void push_run(int n, logic [15:0] limit);
        t_ep0_reply r;
        if (int'(limit) < n) begin
            n = int'(limit);
        end
        if (n == 0) begin
            push_single(1'b0, 1'b0, 7'd0);
            return;
        end
        for (int k = 0; k < n; k++) begin
            r = '0;
            r.has_data = 1'b1;
            r.data     = desc[k];
            r.last     = (k + 1 == n);
            pending_replies.push_back(r);
        end
        bytes_sent = 6'(n);
    endfunction

    // work out the results of one accepted command
    function void predict_replies(t_ep0_cmd c);
        logic [7:0] dtype;
        logic [7:0] didx;
        logic [7:0] os_sig[7];
        int         chars;
        int         slot;
        os_sig = '{8'h4d, 8'h53, 8'h46, 8'h54, 8'h31, 8'h30, 8'h30};
        dtype  = c.value[15:8];
        didx   = c.value[7:0];
        cmd_count++;
        if (c.bus_reset) begin
            configured = 1'b0;
            bytes_sent = 6'd0;
            return;
        end
        foreach (desc[i]) begin
            desc[i] = 8'h00;
        end
        // vendor and class requests: only the compatible-ID read is answered
        if (c.rtype[6:5] != 2'b00) begin
            if (c.rtype != VENDOR_IN_TYPE || c.code != vendor_code || c.value != 16'h0
                || c.index != COMPAT_INDEX) begin
                push_single(1'b1, 1'b0, 7'd0);
            end else begin
                desc[0] = 8'h28;
                desc[5] = 8'h01;
                desc[6] = 8'h04;
                desc[8] = 8'h01;
                desc[17] = 8'h01;
                desc[18] = 8'h57;
                desc[19] = 8'h49;
                desc[20] = 8'h4e;
                desc[21] = 8'h55;
                desc[22] = 8'h53;
                desc[23] = 8'h42;
                push_run(40, c.length);
            end
            return;
        end
        case (c.code)
            REQ_GET_STATUS: push_run(2, c.length);
            REQ_SET_ADDRESS: push_single(1'b0, 1'b1, c.value[6:0]);
            REQ_GET_CONFIGURATION: begin
                desc[0] = {7'd0, configured};
                push_run(1, c.length);
            end
            REQ_SET_CONFIGURATION: begin
                if (c.value > 16'd1) begin
                    push_single(1'b1, 1'b0, 7'd0);
                end else begin
                    configured = c.value[0];
                    push_single(1'b0, 1'b0, 7'd0);
                end
            end
            REQ_GET_INTERFACE: push_run(1, c.length);
            REQ_SET_INTERFACE: begin
                push_single(c.value != 16'h0 || c.index != 16'h0, 1'b0, 7'd0);
            end
            REQ_GET_DESCRIPTOR: begin
                case (dtype)
                    DT_DEVICE: begin
                        desc[0]  = 8'd18;
                        desc[1]  = DT_DEVICE;
                        desc[3]  = 8'h02;
                        desc[7]  = 8'(EP0_PACKET_SIZE);
                        desc[8]  = vendor_id[7:0];
                        desc[9]  = vendor_id[15:8];
                        desc[10] = product_id[7:0];
                        desc[11] = product_id[15:8];
                        desc[12] = release_bcd[7:0];
                        desc[13] = release_bcd[15:8];
                        // string indices drop to zero past the last string
                        for (int k = 1; k <= 3; k++) begin
                            desc[13 + k] = (k <= STRING_COUNT) ? 8'(k) : 8'h00;
                        end
                        desc[17] = 8'h01;
                        push_run(18, c.length);
                    end
                    DT_CONFIG, DT_OTHER_SPD: begin
                        if (didx != 8'h00) begin
                            push_single(1'b1, 1'b0, 7'd0);
                        end else begin
                            desc[0]  = 8'h09;
                            desc[1]  = dtype;
                            desc[2]  = 8'd18;
                            desc[4]  = 8'h01;
                            desc[5]  = 8'h01;
                            desc[7]  = 8'h80;
                            desc[8]  = power_2ma;
                            desc[9]  = 8'h09;
                            desc[10] = 8'h04;
                            desc[14] = 8'hff;
                            push_run(18, c.length);
                        end
                    end
                    DT_QUALIFIER: begin
                        desc[0] = 8'd10;
                        desc[1] = DT_QUALIFIER;
                        desc[3] = 8'h02;
                        desc[7] = 8'(EP0_PACKET_SIZE);
                        desc[8] = 8'h01;
                        push_run(10, c.length);
                    end
                    DT_STRING: begin
                        if (didx == 8'h00) begin
                            // language list: English (US)
                            desc[0] = 8'd4;
                            desc[1] = DT_STRING;
                            desc[2] = 8'h09;
                            desc[3] = 8'h04;
                            push_run(4, c.length);
                        end else if (didx == STR_IDX_OS) begin
                            desc[0] = 8'd18;
                            desc[1] = DT_STRING;
                            for (int k = 0; k < 7; k++) begin
                                desc[2 + 2 * k] = os_sig[k];
                            end
                            desc[16] = vendor_code;
                            push_run(18, c.length);
                        end else if (int'(didx) > STRING_COUNT) begin
                            push_single(1'b1, 1'b0, 7'd0);
                        end else begin
                            // UTF-16LE: text byte then a zero byte
                            slot  = int'(didx) - 1;
                            chars = str_text[slot].len();
                            if (chars > MAX_STRING_CHARS) begin
                                chars = MAX_STRING_CHARS;
                            end
                            for (int k = 0; k < chars; k++) begin
                                desc[2 + 2 * k] = 8'(str_text[slot][k]);
                            end
                            desc[0] = 8'(2 + 2 * chars);
                            desc[1] = DT_STRING;
                            push_run(2 + 2 * chars, c.length);
                        end
                    end
                    default: push_single(1'b1, 1'b0, 7'd0);
                endcase
            end
            default: push_single(1'b1, 1'b0, 7'd0);
        endcase
    endfunction

    // compare one result strobe with the oldest expectation
    function void check_result(t_ep0_reply got);
        t_ep0_reply want;
        reply_count++;
        if (pending_replies.size() == 0) begin
            $error("unexpected result: status %0d has_data %0d data_byte 0x%02h last %0d",
                   got.status, got.has_data, got.data, got.last);
            err_count++;
            return;
        end
        want = pending_replies.pop_front();
        if (got.has_data) begin
            byte_count++;
        end
        if (got.status != want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            err_count++;
        end
        if (got.has_data != want.has_data) begin
            $error("has_data: expected %0d, got %0d", want.has_data, got.has_data);
            err_count++;
        end
        if (got.data != want.data) begin
            $error("data_byte: expected 0x%02h, got 0x%02h", want.data, got.data);
            err_count++;
        end
        if (got.last != want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            err_count++;
        end
        if (got.addr_valid != want.addr_valid) begin
            $error("address_valid: expected %0d, got %0d", want.addr_valid, got.addr_valid);
            err_count++;
        end
        if (got.addr != want.addr) begin
            $error("new_address: expected 0x%02h, got 0x%02h", want.addr, got.addr);
            err_count++;
        end
    endfunction
endclass

module tb_top;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int RANDOM_PER_PHASE = 90;
    localparam int SETTLE_CYCLES    = 8;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_req_type;
    logic [7:0]  i_request_type;
    logic [7:0]  i_request_code;
    logic [15:0] i_setup_value;
    logic [15:0] i_setup_index;
    logic [15:0] i_setup_length;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        o_strobe;
    logic        o_status;
    logic        o_has_data;
    logic [7:0]  o_data_byte;
    logic        o_last;
    logic        o_address_valid;
    logic [6:0]  o_new_address;

    ep0_reply_scoreboard sb;
    int cycle_count = 0;

    usb_ep0_request_responder_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_req_type      (i_req_type),
        .i_request_type  (i_request_type),
        .i_request_code  (i_request_code),
        .i_setup_value   (i_setup_value),
        .i_setup_index   (i_setup_index),
        .i_setup_length  (i_setup_length),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_strobe        (o_strobe),
        .o_status        (o_status),
        .o_has_data      (o_has_data),
        .o_data_byte     (o_data_byte),
        .o_last          (o_last),
        .o_address_valid (o_address_valid),
        .o_new_address   (o_new_address)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result monitor, sampled mid-cycle
    always @(negedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            sb.check_result({o_status, o_has_data, o_data_byte, o_last,
                             o_address_valid, o_new_address});
        end
    end

    function automatic t_ep0_cmd mk_setup(logic [7:0] rt, logic [7:0] rc, logic [15:0] val,
                                          logic [15:0] idx, logic [15:0] len);
        t_ep0_cmd c;
        c.bus_reset = 1'b0;
        c.rtype     = rt;
        c.code      = rc;
        c.value     = val;
        c.index     = idx;
        c.length    = len;
        return c;
    endfunction

    // mostly well-formed requests with random content, some noise
    function automatic t_ep0_cmd random_cmd();
        t_ep0_cmd   c;
        logic [7:0] dtype;
        logic [7:0] didx;
        int         pick;
        c.bus_reset = 1'b0;
        case ($urandom_range(0, 2))
            0:       c.rtype = 8'h80;
            1:       c.rtype = 8'h00;
            default: c.rtype = 8'($urandom) & 8'h9f;
        endcase
        c.code  = 8'($urandom);
        c.value = 16'($urandom);
        c.index = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h0;
        case ($urandom_range(0, 5))
            0:       c.length = 16'h0;
            1:       c.length = 16'($urandom_range(1, 8));
            2:       c.length = 16'($urandom_range(1, 46));
            3:       c.length = 16'hffff;
            4:       c.length = 16'($urandom);
            default: c.length = 16'($urandom_range(40, 64));
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            c.bus_reset = 1'b1;
        end else if (pick < 14) begin
            c.rtype = 8'($urandom);
        end else if (pick < 22) begin
            c = mk_setup(VENDOR_IN_TYPE, sb.vendor_code, 16'h0, COMPAT_INDEX, c.length);
            case ($urandom_range(0, 5))
                0:       c.rtype = 8'($urandom) | 8'h20;
                1:       c.code = c.code ^ 8'($urandom_range(1, 255));
                2:       c.value = 16'($urandom_range(1, 65535));
                3:       c.index = 16'($urandom);
                default: ;
            endcase
        end else if (pick < 50) begin
            c.code = REQ_GET_DESCRIPTOR;
            case ($urandom_range(0, 6))
                0:       dtype = DT_DEVICE;
                1:       dtype = DT_CONFIG;
                2, 5:    dtype = DT_STRING;
                3:       dtype = DT_QUALIFIER;
                4:       dtype = DT_OTHER_SPD;
                default: dtype = 8'($urandom);
            endcase
            if (dtype == DT_STRING) begin
                case ($urandom_range(0, 5))
                    0:       didx = 8'h00;
                    1:       didx = 8'h01;
                    2:       didx = 8'h02;
                    3:       didx = 8'h03;
                    4:       didx = STR_IDX_OS;
                    default: didx = 8'($urandom);
                endcase
            end else begin
                didx = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00;
            end
            c.value = {dtype, didx};
        end else begin
            case ($urandom_range(0, 7))
                0: c.code = REQ_GET_STATUS;
                1: c.code = REQ_SET_ADDRESS;
                2: c.code = REQ_GET_CONFIGURATION;
                3: begin
                    c.code = REQ_SET_CONFIGURATION;
                    if ($urandom_range(0, 3) != 0) begin
                        c.value = 16'($urandom_range(0, 2));
                    end
                end
                4: c.code = REQ_GET_INTERFACE;
                5: begin
                    c.code = REQ_SET_INTERFACE;
                    if ($urandom_range(0, 3) != 0) begin
                        c.value = 16'h0;
                    end
                end
                default: ;
            endcase
        end
        return c;
    endfunction

    // one command transaction; returns just after the accepting edge
    task automatic send_cmd(input t_ep0_cmd c);
        start          <= 1'b1;
        i_req_type     <= c.bus_reset;
        i_request_type <= c.rtype;
        i_request_code <= c.code;
        i_setup_value  <= c.value;
        i_setup_index  <= c.index;
        i_setup_length <= c.length;
        @(negedge i_clk);
        while (busy) begin
            @(negedge i_clk);
        end
        sb.predict_replies(c);
        @(posedge i_clk);
    endtask

    // random commands in bursts; no gaps when back_to_back is set
    task automatic run_random(input int count, input bit back_to_back);
        int left;
        int burst;
        int gap;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 8);
            for (int k = 0; k < burst && left > 0; k++) begin
                send_cmd(random_cmd());
                left--;
            end
            gap = (back_to_back || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (left > 0 && gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // let every expected result arrive, then let the block settle
    task automatic drain();
        start <= 1'b0;
        while (sb.pending_replies.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [15:0] vid, input logic [15:0] pid,
                                input logic [15:0] rel, input logic [15:0] pwr,
                                input logic [15:0] vcode);
        logic [15:0] vals[5];
        logic [2:0]  idxs[5];
        vals = '{vid, pid, rel, pwr, vcode};
        idxs = '{CFG_VENDOR_ID, CFG_PRODUCT_ID, CFG_DEVICE_RELEASE, CFG_MAX_POWER,
                 CFG_VENDOR_CODE};
        for (int k = 0; k < 5; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idxs[k];
            i_cfg_data  <= vals[k];
            sb.set_reg(idxs[k], vals[k]);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        t_ep0_cmd directed[$];
        t_ep0_cmd c;
        sb = new();
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_req_type     <= 1'b0;
        i_request_type <= 8'h0;
        i_request_code <= 8'h0;
        i_setup_value  <= 16'h0;
        i_setup_index  <= 16'h0;
        i_setup_length <= 16'h0;
        i_cfg_we       <= 1'b0;
        i_cfg_index    <= 3'd0;
        i_cfg_data     <= 16'h0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at reset register values
        directed.push_back(mk_setup(8'h80, REQ_GET_STATUS, 16'h0, 16'h0, 16'hffff));
        directed.push_back(mk_setup(8'h80, REQ_GET_STATUS, 16'h0, 16'h0, 16'h0));
        directed.push_back(mk_setup(8'h00, REQ_SET_ADDRESS, 16'hff7f, 16'h0, 16'h0));
        directed.push_back(mk_setup(8'h80, REQ_GET_DESCRIPTOR, {DT_DEVICE, 8'h00}, 16'h0,
                                    16'hffff));
        directed.push_back(mk_setup(8'h80, REQ_GET_DESCRIPTOR, {DT_CONFIG, 8'h00}, 16'h0,
                                    16'hffff));
        directed.push_back(mk_setup(8'h80, REQ_GET_DESCRIPTOR, {DT_CONFIG, 8'h01}, 16'h0,
                                    16'hffff));
        directed.push_back(mk_setup(8'h80, REQ_GET_DESCRIPTOR, {DT_OTHER_SPD, 8'h00}, 16'h0,
                                    16'd9));
        directed.push_back(mk_setup(8'h80, REQ_GET_DESCRIPTOR, {DT_QUALIFIER, 8'h00}, 16'h0,
                                    16'hffff));
        directed.push_back(mk_setup(8'h80, REQ_GET_DESCRIPTOR, {DT_STRING, 8'h00}, 16'h0409,
                                    16'd255));
        directed.push_back(mk_setup(8'h80, REQ_GET_DESCRIPTOR, {DT_STRING, 8'h01}, 16'h0409,
                                    16'hffff));
        directed.push_back(mk_setup(8'h80, REQ_GET_DESCRIPTOR, {DT_STRING, 8'h02}, 16'h0409,
                                    16'hffff));
        directed.push_back(mk_setup(8'h80, REQ_GET_DESCRIPTOR, {DT_STRING, 8'h04}, 16'h0409,
                                    16'hffff));
        directed.push_back(mk_setup(8'h80, REQ_GET_DESCRIPTOR, {DT_STRING, STR_IDX_OS}, 16'h0,
                                    16'hffff));
        directed.push_back(mk_setup(8'h80, REQ_GET_DESCRIPTOR, 16'hff00, 16'h0, 16'hffff));
        directed.push_back(mk_setup(8'h00, REQ_SET_CONFIGURATION, 16'h1, 16'h0, 16'h0));
        directed.push_back(mk_setup(8'h80, REQ_GET_CONFIGURATION, 16'h0, 16'h0, 16'h1));
        directed.push_back(mk_setup(8'h00, REQ_SET_CONFIGURATION, 16'h2, 16'h0, 16'h0));
        c = '0;
        c.bus_reset = 1'b1;
        directed.push_back(c);
        // direction and recipient bits set on a standard request
        directed.push_back(mk_setup(8'h9f, REQ_GET_CONFIGURATION, 16'h0, 16'h0, 16'hffff));
        directed.push_back(mk_setup(8'h81, REQ_GET_INTERFACE, 16'h0, 16'h0, 16'h1));
        directed.push_back(mk_setup(8'h01, REQ_SET_INTERFACE, 16'h0, 16'h0, 16'h0));
        directed.push_back(mk_setup(8'h01, REQ_SET_INTERFACE, 16'h0, 16'h1, 16'h0));
        directed.push_back(mk_setup(VENDOR_IN_TYPE, sb.vendor_code, 16'h0, COMPAT_INDEX,
                                    16'hffff));
        directed.push_back(mk_setup(8'hff, sb.vendor_code, 16'h0, COMPAT_INDEX, 16'hffff));
        directed.push_back(mk_setup(8'h00, 8'hff, 16'h0, 16'h0, 16'h0));
        foreach (directed[i]) begin
            send_cmd(directed[i]);
        end
        drain();
        run_random(RANDOM_PER_PHASE, 1'b0);
        drain();

        // register settings: all low, all high, then two random ones
        program_regs(16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
        run_random(RANDOM_PER_PHASE, 1'b0);
        drain();
        program_regs(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        run_random(RANDOM_PER_PHASE, 1'b0);
        drain();
        program_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom));
        run_random(RANDOM_PER_PHASE, 1'b1);
        drain();
        program_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom));
        run_random(RANDOM_PER_PHASE, 1'b0);
        drain();

        $display("Sent %0d command transactions (%0d directed) over 5 register settings.",
                 sb.cmd_count, directed.size());
        $display("Checked %0d results: %0d reply bytes, %0d stalls.",
                 sb.reply_count, sb.byte_count, sb.stall_count);
        if (sb.err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
